>>> src/swrf_pkg.sv
// Package for the range-filtered stack: payload structs, command and status
// codes, controller states and default sizes.
// No dependencies; the core and the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package swrf_pkg;

    // Sizes fixed by the payload format
    localparam int VALUE_W       = 32;
    localparam int DEPTH_W       = 6;
    localparam int DEPTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_FILTER = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILT
    } t_state;

    typedef struct packed {
        t_cmd                       command;
        logic signed [VALUE_W-1:0]  push_value;
        logic signed [VALUE_W-1:0]  range_low;
        logic signed [VALUE_W-1:0]  range_high;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        t_status                    status;
        logic [DEPTH_W-1:0]         depth;
    } t_out;

endpackage

`default_nettype wire

>>> src/swrf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing but the port widths given by its parameters.
`timescale 1ns / 1ps
`default_nettype none

module swrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/stack_with_range_filter_core.sv
// Top level of the bounded LIFO stack with an inclusive range filter.
// Depends on swrf_pkg and swrf_ram (entry storage).
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------
//  command | in        | i_in_valid / o_in_stall     | i_in_data  (t_in)
//  result  | out       | o_out_valid / i_out_stall   | o_out_data (t_out)
//
// Push and every refused or empty command are answered straight from S_IDLE. Pop and peek
// go through S_READ for the read of the top entry from the RAM.
// Filter goes through S_FILT, where the RAM delivers one entry per cycle and
// matches are written back in place at the compaction pointer.
// Reset empties the stack at once; entry contents are not cleared.
// A result waits in the output register while i_out_stall is high; a new
// transfer is taken in the same cycle as the held result leaves.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_range_filter_core #(
    parameter int DEPTH = swrf_pkg::DEPTH_DEFAULT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire swrf_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output swrf_pkg::t_out      o_out_data
);

    import swrf_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_rd, n_rd;
    logic [CW-1:0]             r_wr, n_wr;
    t_cmd                      r_cmd, n_cmd;
    logic signed [VALUE_W-1:0] r_lo, n_lo;
    logic signed [VALUE_W-1:0] r_hi, n_hi;
    logic                      r_out_valid, n_out_valid;
    t_out                      r_out, n_out;

    logic                      out_free;
    logic                      accept;
    logic                      is_empty;
    logic                      is_full;
    logic [CW-1:0]             cnt_m1;
    logic [CW-1:0]             cnt_p1;
    logic                      in_range;
    logic [CW-1:0]             wr_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic signed [VALUE_W-1:0] ram_rdata;

    swrf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake and status decode
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == CW'(DEPTH));
    assign cnt_m1     = r_count - CW'(1);
    assign cnt_p1     = r_count + CW'(1);
    assign in_range   = (ram_rdata >= r_lo) && (ram_rdata <= r_hi);
    assign wr_next    = r_wr + CW'(in_range);

    // Next state, RAM access and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_cmd       = r_cmd;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = i_in_data.push_value;
        ram_raddr   = r_rd[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_in_data.command;
                    case (i_in_data.command)
                        CMD_PUSH: begin
                            n_out_valid      = 1'b1;
                            n_out.read_value = '0;
                            if (is_full) begin
                                n_out.status = ST_FULL;
                                n_out.depth  = DEPTH_W'(r_count);
                            end else begin
                                ram_we       = 1'b1;
                                n_count      = cnt_p1;
                                n_out.status = ST_OK;
                                n_out.depth  = DEPTH_W'(cnt_p1);
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (is_empty) begin
                                n_out_valid      = 1'b1;
                                n_out.read_value = '0;
                                n_out.status     = ST_EMPTY;
                                n_out.depth      = '0;
                            end else begin
                                ram_raddr = cnt_m1[AW-1:0];
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                n_out_valid      = 1'b1;
                                n_out.read_value = '0;
                                n_out.status     = ST_EMPTY;
                                n_out.depth      = '0;
                            end else begin
                                ram_raddr = '0;
                                n_rd      = CW'(1);
                                n_wr      = '0;
                                n_lo      = i_in_data.range_low;
                                n_hi      = i_in_data.range_high;
                                n_state   = S_FILT;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                // top entry is on the RAM read port
                n_out_valid      = 1'b1;
                n_out.read_value = ram_rdata;
                n_out.status     = ST_OK;
                if (r_cmd == CMD_POP) begin
                    n_count     = cnt_m1;
                    n_out.depth = DEPTH_W'(cnt_m1);
                end else begin
                    n_out.depth = DEPTH_W'(r_count);
                end
                n_state = S_IDLE;
            end
            S_FILT: begin
                // check the entry just read; keep it at the compaction pointer
                if (in_range) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                n_wr = wr_next;
                if (r_rd < r_count) begin
                    ram_raddr = r_rd[AW-1:0];
                    n_rd      = r_rd + CW'(1);
                end else begin
                    n_count          = wr_next;
                    n_out_valid      = 1'b1;
                    n_out.read_value = '0;
                    n_out.status     = ST_OK;
                    n_out.depth      = DEPTH_W'(wr_next);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_rd  <= n_rd;
        r_wr  <= n_wr;
        r_cmd <= n_cmd;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> src/swrf_checker.sv
// Port-level checks for stack_with_range_filter_core, attached by bind.
// Depends on swrf_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module swrf_checker #(
    parameter int DEPTH = swrf_pkg::DEPTH_DEFAULT
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire swrf_pkg::t_out o_out_data
);

    import swrf_pkg::*;

    // No result is shown in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A refused push reports a full stack
    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |->
            o_out_data.depth == DEPTH_W'(DEPTH))
        else $error("full status with wrong depth");

    // Empty status means nothing read and nothing held
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY |->
            o_out_data.depth == '0 && o_out_data.read_value == '0)
        else $error("empty status with data or depth");

    // Depth never exceeds the capacity when it fits the field
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && DEPTH < 64 |-> o_out_data.depth <= DEPTH_W'(DEPTH))
        else $error("depth above capacity");

endmodule

bind stack_with_range_filter_core swrf_checker #(.DEPTH(DEPTH)) u_swrf_checker (.*);

`default_nettype wire
